// ===== hdl/disk_head_scheduler_macros.svh =====
// Assertion macros for the disk head scheduler
`ifndef DISK_HEAD_SCHEDULER_MACROS_SVH
`define DISK_HEAD_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define DHS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("disk head scheduler check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define DHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("disk head scheduler check failed");
`else
`define DHS_ASSERT_IMP(label, ante, cons)
`define DHS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/dhs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
package dhs_pkg;
  localparam int QUEUE_DEPTH  = 32;
  localparam int CYL_BITS     = 12;
  localparam int IDX_BITS     = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int CCNT_BITS    = CYL_BITS + 1;
  localparam int TOTAL_BITS   = 18;
  localparam int MODE_BITS    = 3;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CCNT_BITS-1:0] CYL_SPAN = CCNT_BITS'(1) << CYL_BITS;
  localparam logic [CNT_BITS-1:0]  QUEUE_FULL = CNT_BITS'(QUEUE_DEPTH);

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MODE   = 2'd0;
  localparam cfg_idx_t REG_START  = 2'd1;
  localparam cfg_idx_t REG_CCOUNT = 2'd2;

  typedef logic [MODE_BITS-1:0] mode_t;
  localparam mode_t MODE_FCFS  = 3'd0;
  localparam mode_t MODE_SSTF  = 3'd1;
  localparam mode_t MODE_SCAN  = 3'd2;
  localparam mode_t MODE_CSCAN = 3'd3;
  localparam mode_t MODE_LOOK  = 3'd4;
  localparam mode_t MODE_CLOOK = 3'd5;

  typedef enum logic [1:0] {SET_ALL, SET_LOW, SET_HIGH} set_sel_t;
  typedef enum logic [1:0] {KEY_FIRST, KEY_NEAR, KEY_ASC, KEY_DESC} key_sel_t;
  typedef enum logic [1:0] {SRC_BEST, SRC_ZERO, SRC_END} src_sel_t;

  typedef struct packed {
    logic     scan_start;
    set_sel_t set_sel;
    key_sel_t key_sel;
    logic     emit;
    src_sel_t src;
    logic     jump;
    logic     flush;
    logic     finish;
  } dhs_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic head_zero;
    logic head_end;
    logic pend_v;
    logic out_free;
  } dhs_sts_t;
endpackage

// ===== hdl/dhs_datapath.sv =====
// Request queue, selection scan, head/total tracking and result registers
module dhs_datapath import dhs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic                  sched_start,
  input  logic [CYL_BITS-1:0]   in_cyl,
  input  logic [CYL_BITS-1:0]   start_pos,
  input  logic [CCNT_BITS-1:0]  cyl_count,
  input  dhs_cmd_t              cmd,
  output dhs_sts_t              sts,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [CYL_BITS-1:0]   out_target,
  output logic [CYL_BITS-1:0]   out_dist,
  output logic [TOTAL_BITS-1:0] out_total,
  output logic                  out_last
);
  logic [CYL_BITS-1:0]   mem [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]   cnt_r, sc_r;
  logic                  scanning_r, cmp_v_r, found_r;
  logic [IDX_BITS-1:0]   cmp_idx_r, best_idx_r;
  logic [CYL_BITS-1:0]   rd_data_r, best_val_r, best_key_r;
  logic [QUEUE_DEPTH-1:0] served_r;
  logic [CYL_BITS-1:0]   head_r;
  logic [TOTAL_BITS-1:0] total_r;
  logic                  pend_v_r;
  logic [CYL_BITS-1:0]   pend_tgt_r, pend_dist_r;
  logic [TOTAL_BITS-1:0] pend_tot_r;
  logic                  out_v_r, out_last_r;
  logic [CYL_BITS-1:0]   out_tgt_r, out_dist_r;
  logic [TOTAL_BITS-1:0] out_tot_r;

  logic [CYL_BITS-1:0]   end_cyl, key, tgt, mv_dist;
  logic                  elig, take, scan_done, out_free, load_out;
  logic [TOTAL_BITS:0]   sum_emit, sum_jump;
  logic [TOTAL_BITS-1:0] tot_emit, tot_jump;

  always_comb begin
    if (cyl_count == '0) begin
      end_cyl = '0;
    end else if (cyl_count > CYL_SPAN) begin
      end_cyl = '1;
    end else begin
      end_cyl = CYL_BITS'(cyl_count - CCNT_BITS'(1));
    end
  end

  always_comb begin
    case (cmd.set_sel)
      SET_LOW:  elig = rd_data_r < start_pos;
      SET_HIGH: elig = rd_data_r >= start_pos;
      default:  elig = 1'b1;
    endcase
    elig = elig && !served_r[cmp_idx_r];
    case (cmd.key_sel)
      KEY_NEAR: key = (rd_data_r >= head_r) ? rd_data_r - head_r : head_r - rd_data_r;
      KEY_ASC:  key = rd_data_r;
      KEY_DESC: key = ~rd_data_r;
      default:  key = '0;
    endcase
    take = cmp_v_r && elig && (!found_r || key < best_key_r);
  end

  always_comb begin
    case (cmd.src)
      SRC_ZERO: tgt = '0;
      SRC_END:  tgt = end_cyl;
      default:  tgt = best_val_r;
    endcase
    mv_dist  = (tgt >= head_r) ? tgt - head_r : head_r - tgt;
    sum_emit = {1'b0, total_r} + (TOTAL_BITS+1)'(mv_dist);
    sum_jump = {1'b0, total_r} + (TOTAL_BITS+1)'(end_cyl);
    tot_emit = sum_emit[TOTAL_BITS] ? '1 : sum_emit[TOTAL_BITS-1:0];
    tot_jump = sum_jump[TOTAL_BITS] ? '1 : sum_jump[TOTAL_BITS-1:0];
  end

  assign scan_done = scanning_r && !cmp_v_r && (sc_r == cnt_r);
  assign out_free  = !out_v_r || !out_stall;
  assign load_out  = (cmd.emit && pend_v_r) || cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sc_r       <= '0;
      scanning_r <= 1'b0;
      cmp_v_r    <= 1'b0;
      found_r    <= 1'b0;
      served_r   <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (in_fire && cnt_r < QUEUE_FULL) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
      end
      if (cmd.finish) begin
        cnt_r <= '0;
      end
      if (sched_start) begin
        served_r <= '0;
      end
      if (cmd.scan_start) begin
        scanning_r <= 1'b1;
        sc_r       <= '0;
        found_r    <= 1'b0;
        cmp_v_r    <= 1'b0;
      end else begin
        if (scanning_r) begin
          if (sc_r < cnt_r) begin
            cmp_v_r <= 1'b1;
            sc_r    <= sc_r + CNT_BITS'(1);
          end else begin
            cmp_v_r <= 1'b0;
            if (!cmp_v_r) begin
              scanning_r <= 1'b0;
            end
          end
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
        if (cmd.src == SRC_BEST) begin
          served_r[best_idx_r] <= 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && cnt_r < QUEUE_FULL) begin
      mem[cnt_r[IDX_BITS-1:0]] <= in_cyl;
    end
    if (sc_r < cnt_r) begin
      rd_data_r <= mem[sc_r[IDX_BITS-1:0]];
    end
    cmp_idx_r <= sc_r[IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= cmp_idx_r;
      best_val_r <= rd_data_r;
      best_key_r <= key;
    end
    if (sched_start) begin
      head_r  <= start_pos;
      total_r <= '0;
    end else if (cmd.emit) begin
      head_r  <= tgt;
      total_r <= tot_emit;
    end else if (cmd.jump) begin
      head_r  <= '0;
      total_r <= tot_jump;
    end
    if (cmd.emit) begin
      pend_tgt_r  <= tgt;
      pend_dist_r <= mv_dist;
      pend_tot_r  <= tot_emit;
    end
    if (load_out) begin
      out_tgt_r  <= pend_tgt_r;
      out_dist_r <= pend_dist_r;
      out_tot_r  <= pend_tot_r;
      out_last_r <= cmd.flush;
    end
  end

  assign sts.scan_done = scan_done;
  assign sts.found     = found_r;
  assign sts.head_zero = head_r == '0;
  assign sts.head_end  = head_r == end_cyl;
  assign sts.pend_v    = pend_v_r;
  assign sts.out_free  = out_free;

  assign out_valid  = out_v_r;
  assign out_target = out_tgt_r;
  assign out_dist   = out_dist_r;
  assign out_total  = out_tot_r;
  assign out_last   = out_last_r;
endmodule

// ===== hdl/dhs_ctrl.sv =====
// Schedule sequencer: load, scan, emit, end-of-disk moves and final flush
module dhs_ctrl import dhs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     final_fire,
  input  mode_t    mode,
  input  dhs_sts_t sts,
  output dhs_cmd_t cmd,
  output logic     load_en
);
  typedef enum logic [2:0] {
    S_LOAD, S_NEXT, S_SCAN, S_FIX, S_EMIT, S_JUMP, S_FLUSH
  } state_t;
  typedef enum logic {PH_A, PH_B} phase_t;

  state_t   state_r;
  phase_t   ph_r;
  src_sel_t src_r;
  set_sel_t set_sel;
  key_sel_t key_sel;
  logic     two_phase, has_fix;

  always_comb begin
    set_sel   = SET_ALL;
    key_sel   = KEY_FIRST;
    two_phase = 1'b1;
    has_fix   = 1'b0;
    unique case (mode)
      MODE_SSTF: begin
        key_sel   = KEY_NEAR;
        two_phase = 1'b0;
      end
      MODE_SCAN: begin
        has_fix = 1'b1;
        set_sel = (ph_r == PH_A) ? SET_LOW : SET_HIGH;
        key_sel = (ph_r == PH_A) ? KEY_DESC : KEY_ASC;
      end
      MODE_CSCAN: begin
        has_fix = 1'b1;
        set_sel = (ph_r == PH_A) ? SET_HIGH : SET_LOW;
        key_sel = KEY_ASC;
      end
      MODE_LOOK: begin
        set_sel = (ph_r == PH_A) ? SET_HIGH : SET_LOW;
        key_sel = (ph_r == PH_A) ? KEY_ASC : KEY_DESC;
      end
      MODE_CLOOK: begin
        set_sel = (ph_r == PH_A) ? SET_HIGH : SET_LOW;
        key_sel = KEY_ASC;
      end
      default: begin
        two_phase = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.set_sel = set_sel;
    cmd.key_sel = key_sel;
    cmd.src     = src_r;
    unique case (state_r)
      S_NEXT:  cmd.scan_start = 1'b1;
      S_EMIT:  cmd.emit = !sts.pend_v || sts.out_free;
      S_JUMP:  cmd.jump = 1'b1;
      S_FLUSH: begin
        cmd.flush  = sts.pend_v && sts.out_free;
        cmd.finish = !sts.pend_v || sts.out_free;
      end
      default: ;
    endcase
  end

  assign load_en = state_r == S_LOAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ph_r    <= PH_A;
      src_r   <= SRC_BEST;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (final_fire) begin
            ph_r    <= PH_A;
            state_r <= S_NEXT;
          end
        end
        S_NEXT: state_r <= S_SCAN;
        S_SCAN: begin
          if (sts.scan_done) begin
            if (sts.found) begin
              src_r   <= SRC_BEST;
              state_r <= S_EMIT;
            end else if (two_phase && ph_r == PH_A) begin
              if (has_fix) begin
                state_r <= S_FIX;
              end else begin
                ph_r    <= PH_B;
                state_r <= S_NEXT;
              end
            end else begin
              state_r <= S_FLUSH;
            end
          end
        end
        S_FIX: begin
          if (mode == MODE_SCAN) begin
            if (!sts.head_zero) begin
              src_r   <= SRC_ZERO;
              state_r <= S_EMIT;
            end else begin
              ph_r    <= PH_B;
              state_r <= S_NEXT;
            end
          end else if (!sts.head_end) begin
            src_r   <= SRC_END;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_JUMP;
          end
        end
        S_EMIT: begin
          if (cmd.emit) begin
            unique case (src_r)
              SRC_ZERO: begin
                ph_r    <= PH_B;
                state_r <= S_NEXT;
              end
              SRC_END: state_r <= S_JUMP;
              default: state_r <= S_NEXT;
            endcase
          end
        end
        S_JUMP: begin
          ph_r    <= PH_B;
          state_r <= S_NEXT;
        end
        S_FLUSH: begin
          if (cmd.finish) begin
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== hdl/disk_head_scheduler.sv =====
// Disk head scheduler top level: config registers, sequencer and datapath
// A request without the final mark is written straight into the queue.
// A final request starts a schedule; each result costs one scan of the n stored
// requests (start, scan over the queue, emit) plus result-side stalls.
// Throughput: one request per cycle while loading, no loading while a schedule runs.
// Reset: queue empty, mode FCFS, start 0, cylinder count 4096; no clearing pass.
`include "disk_head_scheduler_macros.svh"
module disk_head_scheduler import dhs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CYL_BITS-1:0]   in_request_cylinder,
  input  logic                  in_final_request,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CYL_BITS-1:0]   out_target_cylinder,
  output logic [CYL_BITS-1:0]   out_move_distance,
  output logic [TOTAL_BITS-1:0] out_total_seek,
  output logic                  out_last_move,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CCNT_BITS-1:0]  cfg_data
);
  mode_t                 mode_r;
  logic [CYL_BITS-1:0]   start_r;
  logic [CCNT_BITS-1:0]  ccount_r;
  logic                  load_en, in_fire, final_fire;
  dhs_cmd_t              cmd;
  dhs_sts_t              sts;

  // Configuration is always taken; the host writes it only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_FCFS;
      start_r  <= '0;
      ccount_r <= CYL_SPAN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[MODE_BITS-1:0];
        REG_START:  start_r  <= cfg_data[CYL_BITS-1:0];
        REG_CCOUNT: ccount_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take requests only while loading; a final request hands over to the sequencer.
  assign in_stall   = !load_en;
  assign in_fire    = in_valid && load_en;
  assign final_fire = in_fire && in_final_request;

  dhs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .final_fire (final_fire),
    .mode       (mode_r),
    .sts        (sts),
    .cmd        (cmd),
    .load_en    (load_en)
  );

  // The datapath holds one finished result back until the next one exists,
  // so the final move of a schedule can carry its last mark.
  dhs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .sched_start (final_fire),
    .in_cyl      (in_request_cylinder),
    .start_pos   (start_r),
    .cyl_count   (ccount_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_target  (out_target_cylinder),
    .out_dist    (out_move_distance),
    .out_total   (out_total_seek),
    .out_last    (out_last_move)
  );

  // A new request never arrives while a result is still held back.
  `DHS_ASSERT_IMP(a_load_no_pending, in_fire, !sts.pend_v)
  // Flushing the held result presents it as the last move.
  `DHS_ASSERT_NEXT(a_flush_last, cmd.flush, out_valid && out_last_move)
  // The sequencer issues at most one of scan start, emit, jump and finish per cycle.
  `DHS_ASSERT_IMP(a_one_action, 1'b1, $onehot0({cmd.scan_start, cmd.emit, cmd.jump, cmd.finish}))
endmodule

// ===== dv/disk_head_scheduler_test.sv =====
// Self-checking testbench for the disk head scheduler
module disk_head_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dhs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  // Allow one full scan pass per result before touching the registers.
  localparam int SETTLE_CYCLES  = 60;
  localparam int RANDOM_ITEMS   = 230;

  typedef struct {
    logic [CYL_BITS-1:0]   target;
    logic [CYL_BITS-1:0]   distance;
    logic [TOTAL_BITS-1:0] total;
    logic                  last;
  } seek_move_t;

  // Predicts the move list of each schedule and checks the results in order.
  class seek_scoreboard;
    mode_t                 mode;
    logic [CYL_BITS-1:0]   start_cyl;
    logic [CCNT_BITS-1:0]  cyl_count;
    logic [CYL_BITS-1:0]   queued[$];
    logic [CYL_BITS-1:0]   head;
    int unsigned           seek_sum;
    seek_move_t            pending_moves[$];
    int                    mismatches;

    function new();
      mode       = MODE_FCFS;
      start_cyl  = '0;
      cyl_count  = CYL_SPAN;
      mismatches = 0;
    endfunction

    function void add_seek(int unsigned d);
      seek_sum += d;
      if (seek_sum > 262143) seek_sum = 262143;
    endfunction

    function void move_to(logic [CYL_BITS-1:0] tgt);
      seek_move_t m;
      int unsigned d;
      d = (tgt > head) ? tgt - head : head - tgt;
      add_seek(d);
      m.target   = tgt;
      m.distance = d[CYL_BITS-1:0];
      m.total    = seek_sum[TOTAL_BITS-1:0];
      m.last     = 1'b0;
      pending_moves.push_back(m);
      head = tgt;
    endfunction

    function void plan_schedule();
      logic [CYL_BITS-1:0] below[$];
      logic [CYL_BITS-1:0] above[$];
      bit served[$];
      int first_new, best;
      int unsigned d, best_d;
      int unsigned span;
      logic [CYL_BITS-1:0] end_cyl;
      first_new = pending_moves.size();
      head = start_cyl;
      seek_sum = 0;
      foreach (queued[i]) begin
        if (queued[i] < head) below.push_back(queued[i]);
        else above.push_back(queued[i]);
      end
      below.sort();
      above.sort();
      case (mode)
        MODE_SSTF: begin
          foreach (queued[i]) served.push_back(1'b0);
          repeat (queued.size()) begin
            best = -1;
            best_d = 0;
            foreach (queued[i]) begin
              if (served[i]) continue;
              d = (queued[i] > head) ? queued[i] - head : head - queued[i];
              // strict compare keeps ties on the earliest loaded request
              if (best < 0 || d < best_d) begin
                best = i;
                best_d = d;
              end
            end
            served[best] = 1'b1;
            move_to(queued[best]);
          end
        end
        MODE_SCAN: begin
          for (int i = below.size() - 1; i >= 0; i--) move_to(below[i]);
          if (head != 0) move_to('0);
          foreach (above[i]) move_to(above[i]);
        end
        MODE_CSCAN: begin
          span = cyl_count;
          if (span == 0) span = 1;
          if (span > CYL_SPAN) span = CYL_SPAN;
          end_cyl = CYL_BITS'(span - 1);
          foreach (above[i]) move_to(above[i]);
          if (head != end_cyl) move_to(end_cyl);
          // wrap to cylinder 0 counts in the total only
          add_seek(end_cyl);
          head = '0;
          foreach (below[i]) move_to(below[i]);
        end
        MODE_LOOK: begin
          foreach (above[i]) move_to(above[i]);
          for (int i = below.size() - 1; i >= 0; i--) move_to(below[i]);
        end
        MODE_CLOOK: begin
          foreach (above[i]) move_to(above[i]);
          foreach (below[i]) move_to(below[i]);
        end
        default: begin
          foreach (queued[i]) move_to(queued[i]);
        end
      endcase
      if (pending_moves.size() > first_new)
        pending_moves[pending_moves.size() - 1].last = 1'b1;
      queued.delete();
    endfunction

    function void note_request(logic [CYL_BITS-1:0] cyl, logic fin);
      // drop requests once the queue is full
      if (queued.size() < QUEUE_DEPTH) queued.push_back(cyl);
      if (fin) plan_schedule();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    endtask

    task check_result(logic [CYL_BITS-1:0] tgt, logic [CYL_BITS-1:0] mv_dist,
                      logic [TOTAL_BITS-1:0] tot, logic last);
      seek_move_t m;
      if (pending_moves.size() == 0) begin
        report_mismatch("unexpected move to cylinder", tgt, -1);
        return;
      end
      m = pending_moves.pop_front();
      if (tgt !== m.target) report_mismatch("target_cylinder", tgt, m.target);
      if (mv_dist !== m.distance) report_mismatch("move_distance", mv_dist, m.distance);
      if (tot !== m.total) report_mismatch("total_seek", tot, m.total);
      if (last !== m.last) report_mismatch("last_move", last, m.last);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CYL_BITS-1:0]   in_request_cylinder = '0;
  logic                  in_final_request = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CYL_BITS-1:0]   out_target_cylinder;
  logic [CYL_BITS-1:0]   out_move_distance;
  logic [TOTAL_BITS-1:0] out_total_seek;
  logic                  out_last_move;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = REG_MODE;
  logic [CCNT_BITS-1:0]  cfg_data = '0;

  seek_scoreboard sb = new();
  int send_idle_pct = 7;
  int recv_stall_pct = 54;
  int quiet_cycles = 0;
  int items_sent = 0;

  disk_head_scheduler dut (.*);

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Check every move the block hands over.
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_target_cylinder, out_move_distance, out_total_seek, out_last_move);

  // Watchdog: end the run when no channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Send one request; hold valid high across back-to-back requests.
  task automatic send_request(logic [CYL_BITS-1:0] cyl, logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_request_cylinder <= cyl;
    in_final_request <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_request(cyl, fin);
    items_sent++;
    // idling mix moves on with the request count
    if (items_sent == 90) begin
      send_idle_pct = 54;
      recv_stall_pct = 7;
    end else if (items_sent == 170) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  // Hold the sender until every predicted move is out, then let the block settle.
  task automatic drain_moves();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_moves.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers while the block is idle.
  task automatic write_config(mode_t m, logic [CYL_BITS-1:0] start,
                              logic [CCNT_BITS-1:0] count);
    cfg_idx_t idx[3];
    logic [CCNT_BITS-1:0] val[3];
    idx = '{REG_MODE, REG_START, REG_CCOUNT};
    val = '{CCNT_BITS'(m), CCNT_BITS'(start), count};
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    sb.mode = m;
    sb.start_cyl = start;
    sb.cyl_count = count;
  endtask

  task automatic send_schedule(logic [CYL_BITS-1:0] cyls[$]);
    foreach (cyls[i]) send_request(cyls[i], i == cyls.size() - 1);
    drain_moves();
  endtask

  function automatic logic [CYL_BITS-1:0] pick_cylinder(logic [CYL_BITS-1:0] prev);
    int r;
    r = $urandom_range(99);
    if (r < 50) return CYL_BITS'($urandom);
    if (r < 70) return sb.start_cyl + CYL_BITS'($urandom_range(8)) - CYL_BITS'(4);
    if (r < 85) return $urandom_range(1) ? '1 : '0;
    return prev;
  endfunction

  initial begin
    logic [CYL_BITS-1:0] cyls[$];
    int len;
    mode_t m;
    logic [CCNT_BITS-1:0] count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, field extremes, each mode and its corner cases.
    send_schedule('{12'd4095, 12'd0, 12'd2048});
    write_config(MODE_SSTF, 12'd100, 13'd4096);
    send_schedule('{12'd110, 12'd90, 12'd100, 12'd95, 12'd105});
    write_config(MODE_SCAN, 12'd0, 13'd4096);
    send_schedule('{12'd7, 12'd0});
    write_config(MODE_SCAN, 12'd2000, 13'd8191);
    send_schedule('{12'd3000, 12'd10, 12'd1999});
    write_config(MODE_CSCAN, 12'd50, 13'd100);
    send_schedule('{12'd4000, 12'd20, 12'd60});
    write_config(MODE_CSCAN, 12'd0, 13'd0);
    send_schedule('{12'd0});
    write_config(MODE_LOOK, 12'd4095, 13'd1);
    send_schedule('{12'd4095, 12'd1, 12'd3000});
    write_config(MODE_CLOOK, 12'd2048, 13'd4096);
    send_schedule('{12'd10, 12'd10, 12'd4000, 12'd2047});
    write_config(mode_t'(6), 12'd1234, 13'd4096);
    send_schedule('{12'd2});
    write_config(mode_t'(7), 12'd2730, 13'd4096);
    send_schedule('{12'd1365});

    // Random schedules; the first one overfills the queue.
    len = 36;
    while (items_sent < RANDOM_ITEMS) begin
      m = mode_t'($urandom_range(7));
      case ($urandom_range(5))
        0: count = '0;
        1: count = 13'd1;
        2: count = CYL_SPAN;
        3: count = '1;
        default: count = CCNT_BITS'($urandom);
      endcase
      write_config(m, $urandom_range(3) == 0 ? ($urandom_range(1) ? '1 : '0)
                                             : CYL_BITS'($urandom), count);
      cyls.delete();
      cyls.push_back(CYL_BITS'($urandom));
      for (int i = 1; i < len; i++) cyls.push_back(pick_cylinder(cyls[i - 1]));
      send_schedule(cyls);
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
    end

    drain_moves();
    if (sb.mismatches == 0 && sb.pending_moves.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
